// ===== sv/mdio_management_frame_master_top_assert.svh =====
// Assertion macros used by the management master frame engine
`ifndef MDIO_MANAGEMENT_FRAME_MASTER_TOP_ASSERT_SVH
`define MDIO_MANAGEMENT_FRAME_MASTER_TOP_ASSERT_SVH

// same-cycle implication
`define MDMF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MDMF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mdmf_pkg.sv =====
// Package: shared constants and types of the management frame master
package mdmf_pkg;

	localparam int PREAMBLE_BITS_DEF = 32;
	localparam int ADDR_W            = 5;
	localparam int DATA_W            = 16;
	localparam int CMD_W             = 2;
	localparam int STATUS_W          = 2;
	localparam int HDR_W             = 2 * ADDR_W;
	localparam int APB_ADDR_W        = 3;
	localparam int APB_DATA_W        = 32;

	localparam logic [ADDR_W-1:0] READ_LIMIT_RST = 5'd8;

	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BUSY   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_IDLE   = 2'd3;

	localparam logic REG_READ_LIMIT = 1'b0;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [ADDR_W-1:0] phy_addr;
		logic [ADDR_W-1:0] reg_addr;
		logic [DATA_W-1:0] write_data;
		logic              mdio_in;
	} item_t;

	typedef struct packed {
		logic                mdio_out;
		logic                mdio_drive;
		logic                mdc_pulse;
		logic                busy_res;
		logic                done_res;
		logic [DATA_W-1:0]   read_data;
		logic [STATUS_W-1:0] status;
	} result_t;

endpackage

// ===== sv/mdmf_cfg.sv =====
// APB register block holding the read PHY address limit
module mdmf_cfg import mdmf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [ADDR_W-1:0]     read_limit
);

	logic [ADDR_W-1:0] limit_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_READ_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= READ_LIMIT_RST;
		end else if (wr_en) begin
			limit_q <= pwdata[ADDR_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_READ_LIMIT) begin
			prdata = {{(APB_DATA_W-ADDR_W){1'b0}}, limit_q};
		end
	end

	assign read_limit = limit_q;

endmodule

// ===== sv/mdmf_engine.sv =====
// Frame engine: input stage, frame state and slot decode, result register
module mdmf_engine import mdmf_pkg::*; #(
	parameter int PREAMBLE_BITS = PREAMBLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ADDR_W-1:0] read_limit,
	input  logic              in_valid,
	output logic              in_ready,
	input  item_t             in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output result_t           out_res
);

	localparam int SLOT_W = $clog2(PREAMBLE_BITS + 34);
	localparam logic [SLOT_W-1:0] S_PRE   = SLOT_W'(PREAMBLE_BITS);
	localparam logic [SLOT_W-1:0] S_ST1   = SLOT_W'(PREAMBLE_BITS + 1);
	localparam logic [SLOT_W-1:0] S_OP0   = SLOT_W'(PREAMBLE_BITS + 2);
	localparam logic [SLOT_W-1:0] S_OP1   = SLOT_W'(PREAMBLE_BITS + 3);
	localparam logic [SLOT_W-1:0] S_HDR   = SLOT_W'(PREAMBLE_BITS + 4);
	localparam logic [SLOT_W-1:0] S_TA0   = SLOT_W'(PREAMBLE_BITS + 14);
	localparam logic [SLOT_W-1:0] S_TA1   = SLOT_W'(PREAMBLE_BITS + 15);
	localparam logic [SLOT_W-1:0] S_DAT   = SLOT_W'(PREAMBLE_BITS + 16);
	localparam logic [SLOT_W-1:0] S_END   = SLOT_W'(PREAMBLE_BITS + 32);
	localparam logic [SLOT_W-1:0] S_LASTR = SLOT_W'(PREAMBLE_BITS + 33);

	item_t             item_s1;
	logic              valid_s1;
	logic              advance;

	logic              active_q;
	logic              is_read_q;
	logic [SLOT_W-1:0] slot_q;
	logic [HDR_W-1:0]  hdr_q;
	logic [DATA_W-1:0] data_q;

	result_t           res_q;
	logic              out_valid_q;

	result_t           res_c;
	logic              start_ok;
	logic              tick_act;
	logic              last;
	logic              shift_en;
	logic              is_start;
	logic [SLOT_W-1:0] hdr_off;
	logic [SLOT_W-1:0] dat_off;
	logic [3:0]        hdr_idx;
	logic [3:0]        dat_idx;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	assign is_start = (item_s1.cmd == CMD_READ) || (item_s1.cmd == CMD_WRITE);
	assign hdr_off  = slot_q - S_HDR;
	assign dat_off  = slot_q - S_DAT;
	assign hdr_idx  = 4'(HDR_W - 1) - hdr_off[3:0];
	assign dat_idx  = ~dat_off[3:0];

	always_comb begin
		res_c    = '0;
		start_ok = 1'b0;
		tick_act = 1'b0;
		last     = 1'b0;
		shift_en = 1'b0;
		if (is_start) begin
			if (active_q) begin
				res_c.status = ST_BUSY;
			end else if (item_s1.cmd == CMD_READ && item_s1.phy_addr > read_limit) begin
				res_c.status = ST_REJECT;
			end else begin
				start_ok = 1'b1;
			end
		end else if (!active_q) begin
			res_c.status = ST_IDLE;
		end else begin
			tick_act         = 1'b1;
			res_c.mdio_drive = 1'b1;
			res_c.mdc_pulse  = 1'b1;
			if (slot_q < S_PRE) begin
				res_c.mdio_out = 1'b1;
			end else if (slot_q == S_PRE) begin
				res_c.mdio_out = 1'b0;
			end else if (slot_q == S_ST1) begin
				res_c.mdio_out = 1'b1;
			end else if (slot_q == S_OP0) begin
				res_c.mdio_out = is_read_q;
			end else if (slot_q == S_OP1) begin
				res_c.mdio_out = !is_read_q;
			end else if (slot_q < S_TA0) begin
				res_c.mdio_out = hdr_q[hdr_idx];
			end else if (is_read_q) begin
				if (slot_q == S_TA0) begin
					res_c.mdio_drive = 1'b0;
					res_c.mdc_pulse  = 1'b0;
				end else if (slot_q == S_TA1) begin
					res_c.mdio_drive = 1'b0;
				end else if (slot_q < S_END) begin
					res_c.mdio_drive = 1'b0;
					shift_en         = 1'b1;
				end else if (slot_q == S_END) begin
					res_c.mdio_out = 1'b1;
				end else begin
					res_c.mdio_drive = 1'b0;
					res_c.mdc_pulse  = 1'b0;
					last             = 1'b1;
				end
			end else begin
				if (slot_q == S_TA0) begin
					res_c.mdio_out = 1'b1;
				end else if (slot_q == S_TA1) begin
					res_c.mdio_out = 1'b0;
				end else if (slot_q < S_END) begin
					res_c.mdio_out = data_q[dat_idx];
				end else begin
					res_c.mdio_drive = 1'b0;
					res_c.mdc_pulse  = 1'b0;
					last             = 1'b1;
				end
			end
			if (last) begin
				res_c.done_res = 1'b1;
				if (is_read_q) begin
					res_c.read_data = data_q;
				end
			end
		end
		res_c.busy_res = start_ok || (tick_act ? !last : active_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			is_read_q <= 1'b0;
			slot_q    <= '0;
		end else if (advance) begin
			if (start_ok) begin
				active_q  <= 1'b1;
				is_read_q <= (item_s1.cmd == CMD_READ);
				slot_q    <= '0;
			end else if (tick_act) begin
				if (last) begin
					active_q <= 1'b0;
					slot_q   <= '0;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (start_ok) begin
				hdr_q  <= {item_s1.phy_addr, item_s1.reg_addr};
				data_q <= (item_s1.cmd == CMD_READ) ? '0 : item_s1.write_data;
			end else if (shift_en) begin
				data_q <= {data_q[DATA_W-2:0], item_s1.mdio_in};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	`include "mdio_management_frame_master_top_assert.svh"

	`MDMF_ASSERT_NOW(a_idle_slot_zero, !active_q, slot_q == '0, "slot index not cleared while idle")
	`MDMF_ASSERT_NOW(a_slot_range, active_q, slot_q <= S_LASTR, "slot index past end of frame")
	`MDMF_ASSERT_NEXT(a_done_ends_frame, advance && res_c.done_res, !active_q, "frame still active after done")
	`MDMF_ASSERT_NOW(a_start_needs_idle, advance && start_ok, !active_q, "frame armed while busy")

endmodule

// ===== sv/mdio_management_frame_master_top.sv =====
// An accepted beat passes the input stage and then the result register; m_axis_tready low holds its result beat.
// Throughput: one beat per cycle while m_axis_tready is high; each tick beat is one management bit slot.
// A frame takes one start beat plus PREAMBLE_BITS+34 (read) or PREAMBLE_BITS+33 (write) tick beats.
// The input stage and the result register let a new beat enter while a result waits.
// arst_n clears frame state and both stages at once; read_phy_limit resets to 8.
module mdio_management_frame_master_top import mdmf_pkg::*; #(
	parameter int PREAMBLE_BITS = PREAMBLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [4:0] phy_addr, [9:5] reg_addr, [25:10] write_data, [26] mdio_in
	input  logic [31:0]           s_axis_tdata,
	// [1:0] cmd
	input  logic [CMD_W-1:0]      s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [0] mdio_out, [1] mdio_drive, [2] mdc_pulse, [3] busy_res, [19:4] read_data
	output logic [23:0]           m_axis_tdata,
	// done_res
	output logic                  m_axis_tlast,
	// [1:0] status
	output logic [STATUS_W-1:0]   m_axis_tuser,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [ADDR_W-1:0] read_limit;
	item_t             in_item;
	result_t           out_res;

	assign in_item.cmd        = s_axis_tuser;
	assign in_item.phy_addr   = s_axis_tdata[4:0];
	assign in_item.reg_addr   = s_axis_tdata[9:5];
	assign in_item.write_data = s_axis_tdata[25:10];
	assign in_item.mdio_in    = s_axis_tdata[26];

	mdmf_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.read_limit (read_limit)
	);

	mdmf_engine #(
		.PREAMBLE_BITS (PREAMBLE_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.read_limit (read_limit),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_item    (in_item),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (out_res)
	);

	assign m_axis_tdata = {4'b0000, out_res.read_data, out_res.busy_res,
		out_res.mdc_pulse, out_res.mdio_drive, out_res.mdio_out};
	assign m_axis_tlast = out_res.done_res;
	assign m_axis_tuser = out_res.status;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the clause 22 management frame master top level
module testbench;
	import mdmf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRE = PREAMBLE_BITS_DEF;
	localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;
	localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = APB_ADDR_W'(4 * REG_READ_LIMIT);
	localparam int HOLD_CYCLES = 120;
	localparam int RANDOM_BEATS = 480;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [CMD_W-1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic m_axis_tlast;
	logic [STATUS_W-1:0] m_axis_tuser;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	// model state of the frame master
	logic [ADDR_W-1:0] read_limit;
	logic frame_on;
	logic frame_is_read;
	logic [6:0] slot_cnt;
	logic [HDR_W-1:0] hdr_bits;
	logic [DATA_W-1:0] data_bits;

	result_t pending_slots[$];
	int mismatches = 0;
	int beats_sent = 0;
	int n_reads = 0;
	int n_writes = 0;
	int n_rejected = 0;
	int n_busy = 0;
	int n_idle = 0;
	bit sender_steady = 0;
	bit sink_steady = 0;
	bit holdoff_req = 0;

	mdio_management_frame_master_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic result_t predict_bit_slot(input item_t it);
		result_t r;
		int s;
		logic last;
		r = '0;
		last = 1'b0;
		if (it.cmd == CMD_READ || it.cmd == CMD_WRITE) begin
			if (frame_on) begin
				r.status = ST_BUSY;
			end else if (it.cmd == CMD_READ && it.phy_addr > read_limit) begin
				r.status = ST_REJECT;
			end else begin
				frame_on = 1'b1;
				frame_is_read = (it.cmd == CMD_READ);
				slot_cnt = '0;
				hdr_bits = {it.phy_addr, it.reg_addr};
				data_bits = frame_is_read ? '0 : it.write_data;
			end
		end else if (!frame_on) begin
			r.status = ST_IDLE;
		end else begin
			s = int'(slot_cnt);
			r.mdio_drive = 1'b1;
			r.mdc_pulse = 1'b1;
			if (s < PRE) begin
				r.mdio_out = 1'b1;
			end else if (s == PRE) begin
				r.mdio_out = 1'b0;
			end else if (s == PRE + 1) begin
				r.mdio_out = 1'b1;
			end else if (s == PRE + 2) begin
				r.mdio_out = frame_is_read;
			end else if (s == PRE + 3) begin
				r.mdio_out = !frame_is_read;
			end else if (s < PRE + 14) begin
				r.mdio_out = hdr_bits[9 - (s - PRE - 4)];
			end else if (frame_is_read) begin
				if (s == PRE + 14) begin
					r.mdio_drive = 1'b0;
					r.mdc_pulse = 1'b0;
				end else if (s == PRE + 15) begin
					r.mdio_drive = 1'b0;
				end else if (s < PRE + 32) begin
					r.mdio_drive = 1'b0;
					data_bits = {data_bits[DATA_W-2:0], it.mdio_in};
				end else if (s == PRE + 32) begin
					r.mdio_out = 1'b1;
				end else begin
					r.mdio_drive = 1'b0;
					r.mdc_pulse = 1'b0;
					last = 1'b1;
				end
			end else begin
				if (s == PRE + 14) begin
					r.mdio_out = 1'b1;
				end else if (s == PRE + 15) begin
					r.mdio_out = 1'b0;
				end else if (s < PRE + 32) begin
					r.mdio_out = data_bits[15 - (s - PRE - 16)];
				end else begin
					r.mdio_drive = 1'b0;
					r.mdc_pulse = 1'b0;
					last = 1'b1;
				end
			end
			if (last) begin
				r.done_res = 1'b1;
				if (frame_is_read)
					r.read_data = data_bits;
				frame_on = 1'b0;
				slot_cnt = '0;
			end else begin
				slot_cnt = slot_cnt + 7'd1;
			end
		end
		r.busy_res = frame_on;
		return r;
	endfunction

	task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] phy,
			input logic [ADDR_W-1:0] reg_a, input logic [DATA_W-1:0] wdata, input logic din);
		item_t it;
		result_t r;
		it = '{cmd, phy, reg_a, wdata, din};
		@(negedge clk);
		while (!sender_steady && $urandom_range(99) < 32) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata <= {5'b0, din, wdata, reg_a, phy};
		s_axis_tuser <= cmd;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		r = predict_bit_slot(it);
		pending_slots.push_back(r);
		beats_sent++;
		case (r.status)
			ST_REJECT: n_rejected++;
			ST_BUSY: n_busy++;
			ST_IDLE: n_idle++;
			default: ;
		endcase
		if (r.done_res) begin
			if (frame_is_read)
				n_reads++;
			else
				n_writes++;
		end
	endtask

	task automatic send_idle_tick();
		send_beat($urandom_range(3) == 0 ? CMD_UNDEF : CMD_TICK, ADDR_W'($urandom),
			ADDR_W'($urandom), DATA_W'($urandom), 1'($urandom));
	endtask

	// start a frame, then feed its bit slots; stray starts land inside at noise_pct percent
	task automatic run_frame(input logic rd, input logic [ADDR_W-1:0] phy,
			input logic [ADDR_W-1:0] reg_a, input logic [DATA_W-1:0] wdata,
			input logic [DATA_W-1:0] line_val, input int noise_pct);
		int n_slots;
		int s;
		logic din;
		logic [CMD_W-1:0] cmd;
		n_slots = rd ? PRE + 34 : PRE + 33;
		send_beat(rd ? CMD_READ : CMD_WRITE, phy, reg_a, wdata, 1'($urandom));
		s = 0;
		while (s < n_slots) begin
			if ($urandom_range(99) < noise_pct) begin
				send_beat($urandom_range(1) ? CMD_READ : CMD_WRITE, ADDR_W'($urandom),
					ADDR_W'($urandom), DATA_W'($urandom), 1'($urandom));
			end else begin
				din = 1'($urandom);
				if (s >= PRE + 16 && s < PRE + 32)
					din = line_val[15 - (s - PRE - 16)];
				cmd = ($urandom_range(9) == 0) ? CMD_UNDEF : CMD_TICK;
				send_beat(cmd, ADDR_W'($urandom), ADDR_W'($urandom), DATA_W'($urandom), din);
				s++;
			end
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_slots.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic check_read_limit();
		logic [APB_DATA_W-1:0] got;
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		paddr <= LIMIT_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== APB_DATA_W'(read_limit)) begin
			if (mismatches < 10)
				$display("read_phy_limit readback: expected %0d, got %0h", read_limit, got);
			mismatches++;
		end
	endtask

	task automatic set_read_limit(input logic [ADDR_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= LIMIT_ADDR;
		pwdata <= {27'($urandom), value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		read_limit = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		check_read_limit();
	endtask

	task automatic test_reset_state();
		check_read_limit();
		send_beat(CMD_TICK, 5'd0, 5'd0, 16'h0000, 1'b0);
		send_beat(CMD_UNDEF, 5'd31, 5'd31, 16'hFFFF, 1'b1);
		send_beat(CMD_READ, 5'd9, 5'd0, 16'h0000, 1'b0);
		send_beat(CMD_READ, 5'd31, 5'd31, 16'hFFFF, 1'b1);
		wait_drained();
	endtask

	task automatic test_directed_frames();
		run_frame(1'b0, 5'd31, 5'd31, 16'hFFFF, 16'h0000, 0);
		run_frame(1'b1, 5'd8, 5'd0, 16'h0000, 16'hA5C3, 0);
		run_frame(1'b1, 5'd0, 5'd31, 16'hFFFF, 16'h0000, 20);
		run_frame(1'b0, 5'd0, 5'd0, 16'h0000, 16'hFFFF, 20);
		run_frame(1'b1, 5'd5, 5'd10, 16'h1234, 16'hFFFF, 0);
		wait_drained();
	endtask

	task automatic test_limit_extremes();
		set_read_limit(5'd0);
		send_beat(CMD_READ, 5'd1, 5'd3, 16'h0000, 1'b0);
		run_frame(1'b1, 5'd0, 5'd21, 16'h0000, 16'h5A5A, 0);
		run_frame(1'b0, 5'd17, 5'd21, 16'hC3A5, 16'h0000, 0);
		wait_drained();
		set_read_limit(5'd31);
		run_frame(1'b1, 5'd31, 5'd10, 16'h0000, 16'h8001, 0);
		wait_drained();
	endtask

	task automatic test_backpressure();
		sender_steady = 1;
		send_beat(CMD_WRITE, 5'd12, 5'd7, 16'h6B3D, 1'b0);
		repeat (4) send_idle_tick();
		holdoff_req = 1;
		repeat (40) send_beat(CMD_TICK, ADDR_W'($urandom), ADDR_W'($urandom),
			DATA_W'($urandom), 1'($urandom));
		sender_steady = 0;
		while (frame_on)
			send_beat(CMD_TICK, ADDR_W'($urandom), ADDR_W'($urandom), DATA_W'($urandom),
				1'($urandom));
		wait_drained();
	endtask

	task automatic random_phase(input int beats);
		int stop;
		int pick;
		logic rd;
		stop = beats_sent + beats;
		while (beats_sent < stop) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				rd = 1'($urandom);
				run_frame(rd, rd ? ADDR_W'($urandom_range(read_limit, 0)) : ADDR_W'($urandom),
					ADDR_W'($urandom), DATA_W'($urandom), DATA_W'($urandom), 3);
			end else if (pick < 85 && read_limit != 5'd31) begin
				send_beat(CMD_READ, ADDR_W'($urandom_range(31, read_limit + 1)),
					ADDR_W'($urandom), DATA_W'($urandom), 1'($urandom));
			end else begin
				repeat ($urandom_range(4, 1)) send_idle_tick();
			end
		end
	endtask

	task automatic test_random_traffic();
		set_read_limit(ADDR_W'($urandom_range(30, 1)));
		random_phase(RANDOM_BEATS / 4);
		wait_drained();
		sender_steady = 1;
		sink_steady = 1;
		set_read_limit(5'd31);
		random_phase(RANDOM_BEATS / 4);
		wait_drained();
		sender_steady = 0;
		sink_steady = 0;
		set_read_limit(5'd0);
		random_phase(RANDOM_BEATS / 4);
		wait_drained();
		set_read_limit(ADDR_W'($urandom));
		random_phase(RANDOM_BEATS / 4);
		wait_drained();
	endtask

	initial begin
		int hold_left;
		hold_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_req) begin
				hold_left = HOLD_CYCLES;
				holdoff_req = 0;
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (sink_steady) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= 32);
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[2], m_axis_tdata[3],
				m_axis_tlast, m_axis_tdata[19:4], m_axis_tuser};
			if (pending_slots.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result beat: %p", got);
				mismatches++;
			end else begin
				want = pending_slots.pop_front();
				if (got !== want) begin
					if (mismatches < 10)
						$display({"slot mismatch: expected out=%0b drv=%0b mdc=%0b busy=%0b done=%0b",
							" rd=%04h st=%0d, got out=%0b drv=%0b mdc=%0b busy=%0b done=%0b",
							" rd=%04h st=%0d"},
							want.mdio_out, want.mdio_drive, want.mdc_pulse, want.busy_res,
							want.done_res, want.read_data, want.status,
							got.mdio_out, got.mdio_drive, got.mdc_pulse, got.busy_res,
							got.done_res, got.read_data, got.status);
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_TICK;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		read_limit = READ_LIMIT_RST;
		frame_on = 1'b0;
		frame_is_read = 1'b0;
		slot_cnt = '0;
		hdr_bits = '0;
		data_bits = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_directed_frames();
		test_limit_extremes();
		test_backpressure();
		test_random_traffic();

		wait_drained();
		repeat (10) @(posedge clk);
		if (pending_slots.size() != 0) begin
			$display("%0d expected result beats never arrived", pending_slots.size());
			mismatches += pending_slots.size();
		end
		$display("Sent %0d beats: %0d read and %0d write frames completed,", beats_sent, n_reads,
			n_writes);
		$display("%0d rejected reads, %0d starts while busy, %0d idle ticks; %0d mismatches",
			n_rejected, n_busy, n_idle, mismatches);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
